// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the address range table unit rtl file
// no dependencies; expects clk_i and rst_ni in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define AR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// implication with an antecedent and a consequent in the same cycle
`define AR_ASSERT_IMP(lbl, ante, cons) \
  `AR_ASSERT(lbl, (ante) |-> (cons))

// implication whose consequent is checked in the cycle after the antecedent
`define AR_ASSERT_NEXT(lbl, ante, cons) \
  `AR_ASSERT(lbl, (ante) |=> (cons))

`endif

// ----- rtl/core/aru_pkg.sv -----
// shared types and codes of the address range table unit
// no dependencies
package aru_pkg;

  // request operation codes
  typedef enum logic {
    FUNC_ADD    = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_e;

  // response status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // request word
  typedef struct packed {
    logic        func;
    logic        table_select;
    logic [63:0] range_base;
    logic [63:0] range_size;
    logic [3:0]  node_id;
    logic [7:0]  region_flags;
  } req_word_t;

  // response word
  typedef struct packed {
    logic        status;
    logic [7:0]  region_count;
    logic [63:0] covered_bytes;
  } rsp_word_t;

endpackage

// ----- rtl/core/aru_intf.sv -----
// valid/ready channel interfaces of the address range table unit
// depends on aru_pkg
interface aru_req_if import aru_pkg::*; ();
  logic      valid;
  logic      ready;
  req_word_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface aru_rsp_if import aru_pkg::*; ();
  logic      valid;
  logic      ready;
  rsp_word_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/address_range_table_add_remove_unit.sv -----
// Address range table unit: two sorted region tables with add and remove.
// Requests enter on req_i, one response word per request leaves on rsp_o.
// Each table keeps up to REGIONS non-overlapping regions (base, length,
// node, flags). An add fills the uncovered gaps of the range and merges
// touching regions with equal node and flags; a remove cuts the range out.
// A request walks the selected table once: every stored region is read
// from the region memory and the new table is written into the idle bank
// of that table, which becomes active when the request completes.
// One request is in flight at a time; req_i.ready is high while the
// walker is idle, even if a response is still waiting.
// A stalled rsp_o holds its word; the walker then waits before it
// commits the next result.
// Reset: both tables hold a single zero entry, count 1, total 0; no
// memory clearing pass is needed.
// A request dropped for lack of room reports status 1 and leaves the
// table untouched.
`include "assert_macros.svh"

module address_range_table_add_remove_unit import aru_pkg::*; #(
  parameter int unsigned REGIONS   = 128,
  parameter int unsigned NODE_NONE = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  aru_req_if.sink   req_i,
  aru_rsp_if.source rsp_o
);

  localparam int unsigned IW        = $clog2(REGIONS);
  localparam int unsigned CW        = $clog2(REGIONS + 1);
  localparam int unsigned AW        = IW + 2;
  localparam int unsigned MEM_DEPTH = 4 * (2 ** IW);

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] len;
    logic [3:0]  node;
    logic [7:0]  flags;
  } entry_t;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_CAP   = 10'b00_0000_0010,
    ST_SETUP = 10'b00_0000_0100,
    ST_RD    = 10'b00_0000_1000,
    ST_SUM   = 10'b00_0001_0000,
    ST_EV    = 10'b00_0010_0000,
    ST_EV2   = 10'b00_0100_0000,
    ST_TAIL  = 10'b00_1000_0000,
    ST_FLUSH = 10'b01_0000_0000,
    ST_FIN   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // request and walk registers
  req_word_t   req_q;
  logic [63:0] size_q, end_q, b_q;
  logic [CW-1:0] idx_q, wp_q;
  logic [CW:0]   need_q;
  logic        skip_q, status_q;
  entry_t      ent_q, pend_q;
  logic [63:0] re_q, pend_end_q, tot_q;
  logic        pv_q;
  entry_t      rd_data_q;

  // committed table state
  logic [CW-1:0] cnt_q [2];
  logic [63:0]   total_q [2];
  logic          bank_q [2];
  logic          fresh_q [2];

  // response register
  logic      rsp_valid_q;
  rsp_word_t rsp_q;

  // region memory, address {bank, table, index}
  entry_t ent_mem_q [MEM_DEPTH];

  logic          tsel, is_rm;
  logic          rd_en, wr_req, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  entry_t        wr_data, x, empty_ent;
  logic [63:0]   x_end, b_d;
  logic          emit, go2, need_inc, can_merge, fail_add, commit, out_free;
  logic [CW:0]   cnt_plus_two, cnt_plus_need;

  assign tsel  = req_q.table_select;
  assign is_rm = (req_q.func == FUNC_REMOVE);
  assign empty_ent = '{base: '0, len: '0, node: 4'(NODE_NONE), flags: '0};

  assign req_i.ready   = (state_q == ST_IDLE);
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  assign cnt_plus_two  = {1'b0, cnt_q[tsel]} + (CW + 1)'(2);
  assign cnt_plus_need = {1'b0, cnt_q[tsel]} + need_q;
  assign fail_add      = !is_rm && (cnt_plus_need > (CW + 1)'(REGIONS));
  assign commit        = !skip_q && !fail_add;
  assign out_free      = !rsp_valid_q || rsp_o.ready;

  // region piece produced by the walk in this cycle
  always_comb begin
    emit     = 1'b0;
    go2      = 1'b0;
    need_inc = 1'b0;
    x        = ent_q;
    x_end    = re_q;
    b_d      = b_q;
    unique case (state_q)
      ST_EV: begin
        emit = 1'b1;
        if (!is_rm) begin
          if (ent_q.len == '0) begin
            x     = '{base: req_q.range_base, len: size_q, node: req_q.node_id,
                      flags: req_q.region_flags};
            x_end = end_q;
            b_d   = end_q;
          end else if (ent_q.base >= end_q) begin
            if (b_q < end_q) begin
              x        = '{base: b_q, len: end_q - b_q, node: req_q.node_id,
                           flags: req_q.region_flags};
              x_end    = end_q;
              need_inc = 1'b1;
              b_d      = end_q;
              go2      = 1'b1;
            end
          end else if (re_q <= b_q) begin
            b_d = b_q;
          end else if (ent_q.base > b_q) begin
            x        = '{base: b_q, len: ent_q.base - b_q, node: req_q.node_id,
                         flags: req_q.region_flags};
            x_end    = ent_q.base;
            need_inc = 1'b1;
            b_d      = (re_q < end_q) ? re_q : end_q;
            go2      = 1'b1;
          end else begin
            b_d = (re_q < end_q) ? re_q : end_q;
          end
        end else begin
          if ((ent_q.base >= end_q) || (re_q <= req_q.range_base)) begin
            emit = 1'b1;
          end else if (ent_q.base < req_q.range_base) begin
            x     = '{base: ent_q.base, len: req_q.range_base - ent_q.base,
                      node: ent_q.node, flags: ent_q.flags};
            x_end = req_q.range_base;
            go2   = (re_q > end_q);
          end else if (re_q > end_q) begin
            x = '{base: end_q, len: re_q - end_q, node: ent_q.node, flags: ent_q.flags};
          end else begin
            emit = 1'b0;
          end
        end
      end
      ST_EV2: begin
        emit = 1'b1;
        if (is_rm) begin
          x = '{base: end_q, len: re_q - end_q, node: ent_q.node, flags: ent_q.flags};
        end
      end
      ST_TAIL: begin
        if (b_q < end_q) begin
          emit     = 1'b1;
          need_inc = 1'b1;
          x        = '{base: b_q, len: end_q - b_q, node: req_q.node_id,
                       flags: req_q.region_flags};
          x_end    = end_q;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // merge stage: extend the pending region or write it out
  assign can_merge = pv_q && !is_rm && (pend_end_q == x.base) &&
                     (pend_q.node == x.node) && (pend_q.flags == x.flags);

  always_comb begin
    wr_req  = 1'b0;
    wr_data = pend_q;
    if (emit) begin
      wr_req = pv_q && !can_merge;
    end else if (state_q == ST_FLUSH) begin
      if (pv_q) begin
        wr_req = 1'b1;
      end else if (is_rm && (wp_q == '0)) begin
        wr_req  = 1'b1;
        wr_data = empty_ent;
      end
    end
  end

  assign wr_en   = wr_req && (wp_q < CW'(REGIONS));
  assign wr_addr = {!bank_q[tsel], tsel, wp_q[IW-1:0]};
  assign rd_en   = (state_q == ST_RD) && (idx_q != cnt_q[tsel]);
  assign rd_addr = {bank_q[tsel], tsel, idx_q[IW-1:0]};

  // memory ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ent_mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= ent_mem_q[rd_addr];
    end
  end

  // walk sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (req_i.valid) state_d = ST_CAP;
      ST_CAP:   state_d = ST_SETUP;
      ST_SETUP: begin
        if ((size_q == '0) || (is_rm && (cnt_plus_two > (CW + 1)'(REGIONS)))) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        if (idx_q == cnt_q[tsel]) begin
          state_d = is_rm ? ST_FLUSH : ST_TAIL;
        end else begin
          state_d = ST_SUM;
        end
      end
      ST_SUM:   state_d = ST_EV;
      ST_EV:    state_d = go2 ? ST_EV2 : ST_RD;
      ST_EV2:   state_d = ST_RD;
      ST_TAIL:  state_d = ST_FLUSH;
      ST_FLUSH: state_d = ST_FIN;
      ST_FIN:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control and committed state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q[0]    <= CW'(1);
      cnt_q[1]    <= CW'(1);
      total_q[0]  <= '0;
      total_q[1]  <= '0;
      bank_q[0]   <= 1'b0;
      bank_q[1]   <= 1'b0;
      fresh_q[0]  <= 1'b1;
      fresh_q[1]  <= 1'b1;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == ST_FIN) && out_free) begin
        rsp_valid_q <= 1'b1;
        if (commit) begin
          cnt_q[tsel]   <= wp_q;
          total_q[tsel] <= tot_q;
          bank_q[tsel]  <= !bank_q[tsel];
          fresh_q[tsel] <= 1'b0;
        end
      end else if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // walk datapath
  always_ff @(posedge clk_i) begin
    // request capture and range clipping
    if (req_i.valid && req_i.ready) begin
      req_q <= req_i.payload;
    end
    if (state_q == ST_CAP) begin
      size_q <= (req_q.range_size < ~req_q.range_base) ? req_q.range_size
                                                       : ~req_q.range_base;
    end
    if (state_q == ST_SETUP) begin
      end_q    <= req_q.range_base + size_q;
      b_q      <= req_q.range_base;
      idx_q    <= '0;
      wp_q     <= '0;
      need_q   <= '0;
      pv_q     <= 1'b0;
      tot_q    <= '0;
      skip_q   <= (size_q == '0) || (is_rm && (cnt_plus_two > (CW + 1)'(REGIONS)));
      status_q <= (size_q != '0);
    end
    // region fetch
    if (rd_en) begin
      idx_q <= idx_q + CW'(1);
    end
    if (state_q == ST_SUM) begin
      ent_q <= fresh_q[tsel] ? '0 : rd_data_q;
      re_q  <= fresh_q[tsel] ? '0 : (rd_data_q.base + rd_data_q.len);
    end
    // cursor and gap count
    if ((state_q == ST_EV) || (state_q == ST_TAIL)) begin
      b_q <= b_d;
    end
    if (need_inc) begin
      need_q <= need_q + (CW + 1)'(1);
    end
    // pending region
    if (emit) begin
      if (can_merge) begin
        pend_q.len <= pend_q.len + x.len;
      end else begin
        pend_q <= x;
      end
      pend_end_q <= x_end;
      pv_q       <= 1'b1;
    end
    if (wr_en) begin
      wp_q  <= wp_q + CW'(1);
      tot_q <= tot_q + wr_data.len;
    end
    // response word
    if ((state_q == ST_FIN) && out_free) begin
      rsp_q.status        <= skip_q ? status_q : (fail_add ? STATUS_FULL : STATUS_OK);
      rsp_q.region_count  <= commit ? 8'(wp_q) : 8'(cnt_q[tsel]);
      rsp_q.covered_bytes <= commit ? tot_q : total_q[tsel];
    end
  end

  // checks
  `AR_ASSERT_IMP(a_wr_idle_bank, wr_en, wr_addr[AW-1] != bank_q[tsel])
  `AR_ASSERT(a_cnt_range, (cnt_q[0] != '0) && (cnt_q[0] <= CW'(REGIONS)))
  `AR_ASSERT_NEXT(a_accept_starts, req_i.valid && req_i.ready, state_q == ST_CAP)
  `AR_ASSERT_IMP(a_rsp_from_fin, $rose(rsp_valid_q), $past(state_q == ST_FIN))

endmodule

// ----- tb/sv/aru_scoreboard.sv -----
// scoreboard for the address range table unit: tracks both region tables
// and checks every response word; depends on aru_pkg and aru_intf
`timescale 1ns / 1ps

module aru_scoreboard import aru_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  aru_req_if   req_mon,
  aru_rsp_if   rsp_mon,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int unsigned NREG      = 128;
  localparam logic [3:0]  NODE_NONE = 4'd8;
  localparam logic [63:0] ADDR_MAX  = '1;

  // shadow copy of both region tables
  logic [63:0] rg_base  [2][NREG];
  logic [63:0] rg_len   [2][NREG];
  logic [3:0]  rg_node  [2][NREG];
  logic [7:0]  rg_flags [2][NREG];
  int unsigned rg_count [2];
  logic [63:0] rg_total [2];

  rsp_word_t expected_rsp_q[$];
  int fails = 0;
  int outstanding = 0;

  assign fail_count_o = fails;
  assign pending_o    = outstanding;

  function automatic void move_region(int t, int dst, int src);
    rg_base[t][dst]  = rg_base[t][src];
    rg_len[t][dst]   = rg_len[t][src];
    rg_node[t][dst]  = rg_node[t][src];
    rg_flags[t][dst] = rg_flags[t][src];
  endfunction

  function automatic void insert_region(int t, int idx, logic [63:0] b, logic [63:0] len,
                                        logic [3:0] nd, logic [7:0] fl);
    int n = rg_count[t];
    if (n >= NREG || idx > n) return;
    for (int k = n; k > idx; k--) move_region(t, k, k - 1);
    rg_base[t][idx]  = b;
    rg_len[t][idx]   = len;
    rg_node[t][idx]  = nd;
    rg_flags[t][idx] = fl;
    rg_count[t]      = n + 1;
    rg_total[t]      = rg_total[t] + len;
  endfunction

  function automatic void delete_region(int t, int r);
    int n = rg_count[t];
    if (r >= n) return;
    rg_total[t] = rg_total[t] - rg_len[t][r];
    for (int k = r; k + 1 < n; k++) move_region(t, k, k + 1);
    n--;
    // an emptied table keeps one blank entry owned by no node
    if (n == 0) begin
      n = 1;
      rg_base[t][0]  = '0;
      rg_len[t][0]   = '0;
      rg_flags[t][0] = '0;
      rg_node[t][0]  = NODE_NONE;
    end
    rg_count[t] = n;
  endfunction

  // fold touching neighbors with equal node and flags
  function automatic void merge_regions(int t);
    int i = 0;
    while (i + 1 < rg_count[t]) begin
      if (rg_base[t][i] + rg_len[t][i] != rg_base[t][i+1] ||
          rg_node[t][i] != rg_node[t][i+1] || rg_flags[t][i] != rg_flags[t][i+1]) begin
        i++;
        continue;
      end
      rg_len[t][i] = rg_len[t][i] + rg_len[t][i+1];
      for (int k = i + 1; k + 1 < rg_count[t]; k++) move_region(t, k, k + 1);
      rg_count[t]--;
    end
  endfunction

  function automatic logic [63:0] clip_size(logic [63:0] b, logic [63:0] s);
    logic [63:0] room = ADDR_MAX - b;
    return (s < room) ? s : room;
  endfunction

  function automatic logic add_range(int t, logic [63:0] base, logic [63:0] size,
                                     logic [3:0] nd, logic [7:0] fl);
    logic [63:0] stop_a, b, rb, re;
    int need, i;
    size   = clip_size(base, size);
    stop_a = base + size;
    if (size == 0) return STATUS_OK;
    // empty table takes the range as its only entry
    if (rg_len[t][0] == 0) begin
      rg_base[t][0]  = base;
      rg_len[t][0]   = size;
      rg_flags[t][0] = fl;
      rg_node[t][0]  = nd;
      rg_total[t]    = size;
      return STATUS_OK;
    end
    // first pass counts the gaps, second pass fills them
    for (int pass = 0; pass < 2; pass++) begin
      b    = base;
      need = 0;
      for (i = 0; i < rg_count[t]; i++) begin
        rb = rg_base[t][i];
        re = rb + rg_len[t][i];
        if (rb >= stop_a) break;
        if (re <= b) continue;
        if (rb > b) begin
          need++;
          if (pass != 0) begin
            insert_region(t, i, b, rb - b, nd, fl);
            i++;
          end
        end
        b = (re < stop_a) ? re : stop_a;
      end
      if (b < stop_a) begin
        need++;
        if (pass != 0) insert_region(t, i, b, stop_a - b, nd, fl);
      end
      if (pass == 0 && rg_count[t] + need > NREG) return STATUS_FULL;
    end
    merge_regions(t);
    return STATUS_OK;
  endfunction

  function automatic logic remove_range(int t, logic [63:0] base, logic [63:0] size);
    logic [63:0] stop_a, rb, re;
    logic [3:0]  nd;
    logic [7:0]  fl;
    int first = 0;
    int last  = 0;
    size   = clip_size(base, size);
    stop_a = base + size;
    if (size == 0) return STATUS_OK;
    if (rg_count[t] + 2 > NREG) return STATUS_FULL;
    for (int idx = 0; idx < rg_count[t]; idx++) begin
      rb = rg_base[t][idx];
      re = rb + rg_len[t][idx];
      nd = rg_node[t][idx];
      fl = rg_flags[t][idx];
      if (rb >= stop_a) break;
      if (re <= base) continue;
      if (rb < base) begin
        // split off the part below the range
        rg_base[t][idx] = base;
        rg_len[t][idx]  = rg_len[t][idx] - (base - rb);
        rg_total[t]     = rg_total[t] - (base - rb);
        insert_region(t, idx, rb, base - rb, nd, fl);
      end else if (re > stop_a) begin
        // split off the part above the range, revisit the inner piece
        rg_base[t][idx] = stop_a;
        rg_len[t][idx]  = rg_len[t][idx] - (stop_a - rb);
        rg_total[t]     = rg_total[t] - (stop_a - rb);
        insert_region(t, idx, rb, stop_a - rb, nd, fl);
        idx--;
      end else begin
        if (last == 0) first = idx;
        last = idx + 1;
      end
    end
    for (int idx = last - 1; idx >= first; idx--) delete_region(t, idx);
    return STATUS_OK;
  endfunction

  // predict on accepted requests, compare on accepted responses
  always @(posedge clk_i or negedge rst_ni) begin
    req_word_t rq;
    rsp_word_t ex, got;
    int t;
    if (!rst_ni) begin
      for (int s = 0; s < 2; s++) begin
        for (int k = 0; k < NREG; k++) begin
          rg_base[s][k]  = '0;
          rg_len[s][k]   = '0;
          rg_node[s][k]  = '0;
          rg_flags[s][k] = '0;
        end
        rg_count[s] = 1;
        rg_total[s] = '0;
      end
      expected_rsp_q.delete();
      outstanding = 0;
    end else begin
      if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
        rq = req_mon.payload;
        t  = int'(rq.table_select);
        if (rq.func == FUNC_REMOVE) ex.status = remove_range(t, rq.range_base, rq.range_size);
        else ex.status = add_range(t, rq.range_base, rq.range_size, rq.node_id,
                                   rq.region_flags);
        ex.region_count  = rg_count[t][7:0];
        ex.covered_bytes = rg_total[t];
        expected_rsp_q.push_back(ex);
      end
      if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
        got = rsp_mon.payload;
        if (expected_rsp_q.size() == 0) begin
          $error("response word with nothing expected: %h", got);
          fails++;
        end else begin
          ex = expected_rsp_q.pop_front();
          if (got.status !== ex.status) begin
            $error("status: expected %0d, actual %0d", ex.status, got.status);
            fails++;
          end
          if (got.region_count !== ex.region_count) begin
            $error("region_count: expected %0d, actual %0d", ex.region_count,
                   got.region_count);
            fails++;
          end
          if (got.covered_bytes !== ex.covered_bytes) begin
            $error("covered_bytes: expected %h, actual %h", ex.covered_bytes,
                   got.covered_bytes);
            fails++;
          end
        end
      end
      outstanding = expected_rsp_q.size();
    end
  end

endmodule

// ----- tb/sv/tb_address_range_table_add_remove_unit.sv -----
// top of the address range table unit testbench: clock, reset, request stimulus
// and response back-pressure; depends on aru_pkg, aru_intf, aru_scoreboard and the unit
`timescale 1ns / 1ps

module tb_address_range_table_add_remove_unit import aru_pkg::*; ();

  localparam logic        TBL_MEM  = 1'b0;
  localparam logic        TBL_RSV  = 1'b1;
  localparam logic [63:0] ADDR_MAX = '1;
  localparam int          RANDOM_ITEMS = 1010;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   fail_count, pending, words_sent;
  bit   long_hold_done;

  aru_req_if req_if ();
  aru_rsp_if rsp_if ();

  address_range_table_add_remove_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  aru_scoreboard u_scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_if),
    .rsp_mon      (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("[address_range_table_add_remove_unit] ERROR");
    $finish;
  end

  function automatic int gap_len();
    int r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic req_word_t make_word(func_e f, logic tbl, logic [63:0] base,
                                          logic [63:0] size, logic [3:0] nd,
                                          logic [7:0] fl);
    req_word_t w;
    w.func         = f;
    w.table_select = tbl;
    w.range_base   = base;
    w.range_size   = size;
    w.node_id      = nd;
    w.region_flags = fl;
    return w;
  endfunction

  // mostly small ranges in a narrow window so gaps, splits and merges happen
  function automatic req_word_t random_word();
    req_word_t w;
    int r = $urandom_range(0, 99);
    w.func         = ($urandom_range(0, 99) < 60) ? FUNC_ADD : FUNC_REMOVE;
    w.table_select = 1'($urandom_range(0, 1));
    w.node_id      = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 8))
                                                 : (($urandom_range(0, 1) != 0) ? 4'd8 : 4'd0);
    w.region_flags = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                 : (($urandom_range(0, 1) != 0) ? 8'hff : 8'h00);
    if (r < 78) begin
      w.range_base = 64'(($urandom_range(0, 255)) * 16);
      w.range_size = ($urandom_range(0, 40) == 0) ? 64'd0 : 64'($urandom_range(1, 96));
    end else if (r < 90) begin
      w.range_base = {$urandom, $urandom};
      w.range_size = {$urandom, $urandom};
    end else if (r < 97) begin
      w.range_base = ADDR_MAX - 64'($urandom_range(0, 300));
      w.range_size = ($urandom_range(0, 1) != 0) ? ADDR_MAX : 64'($urandom_range(0, 400));
    end else begin
      w.func       = FUNC_REMOVE;
      w.range_base = '0;
      w.range_size = ADDR_MAX;
    end
    return w;
  endfunction

  // offer one word, hold it until accepted, then an optional gap
  task automatic send_word(req_word_t w);
    int g;
    req_if.valid   <= 1'b1;
    req_if.payload <= w;
    forever begin
      @(negedge clk_i);
      if (req_if.ready) break;
    end
    @(posedge clk_i);
    words_sent++;
    g = gap_len();
    if (g > 0) begin
      req_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // stop offering until every response word has come back
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // response back-pressure, with one long hold-off
  initial begin
    int hold, free_run, r;
    rsp_if.ready = 1'b0;
    hold = 0;
    free_run = 0;
    long_hold_done = 0;
    forever begin
      @(posedge clk_i);
      r = $urandom_range(0, 999);
      if (hold > 0) begin
        hold--;
        rsp_if.ready <= 1'b0;
      end else if (!long_hold_done && words_sent > 300) begin
        long_hold_done = 1;
        hold = 2000;
        rsp_if.ready <= 1'b0;
      end else if (free_run > 0) begin
        free_run--;
        rsp_if.ready <= 1'b1;
      end else if (r < 20) begin
        free_run = $urandom_range(100, 600);
        rsp_if.ready <= 1'b1;
      end else if (r < 120) begin
        hold = $urandom_range(1, 4);
        rsp_if.ready <= 1'b0;
      end else if (r < 130) begin
        hold = $urandom_range(20, 120);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // stimulus and verdict
  initial begin
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    words_sent     = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words: empty table, overlap, merge, clipping, splits, emptying
    send_word(make_word(FUNC_ADD, TBL_MEM, 64'h100, 64'd0, 4'd1, 8'h01));
    send_word(make_word(FUNC_REMOVE, TBL_MEM, 64'h0, ADDR_MAX, 4'd0, 8'h00));
    send_word(make_word(FUNC_ADD, TBL_MEM, 64'h1000, 64'h100, 4'd1, 8'h01));
    send_word(make_word(FUNC_ADD, TBL_MEM, 64'h0f80, 64'h400, 4'd2, 8'h02));
    send_word(make_word(FUNC_ADD, TBL_MEM, 64'h1380, 64'h80, 4'd2, 8'h02));
    send_word(make_word(FUNC_ADD, TBL_MEM, 64'h2000, 64'h10, 4'd2, 8'h02));
    send_word(make_word(FUNC_REMOVE, TBL_MEM, 64'h1040, 64'h20, 4'd0, 8'h00));
    send_word(make_word(FUNC_REMOVE, TBL_MEM, 64'h0f00, 64'h100, 4'd0, 8'h00));
    send_word(make_word(FUNC_REMOVE, TBL_MEM, 64'h1300, 64'd0, 4'd0, 8'h00));
    send_word(make_word(FUNC_ADD, TBL_MEM, ADDR_MAX, ADDR_MAX, 4'd8, 8'hff));
    send_word(make_word(FUNC_ADD, TBL_MEM, ADDR_MAX - 64'd10, ADDR_MAX, 4'd8, 8'hff));
    send_word(make_word(FUNC_REMOVE, TBL_MEM, 64'h0, ADDR_MAX, 4'd0, 8'h00));
    send_word(make_word(FUNC_ADD, TBL_MEM, 64'h0, ADDR_MAX, 4'd8, 8'hff));
    send_word(make_word(FUNC_REMOVE, TBL_MEM, 64'h0, ADDR_MAX, 4'd0, 8'h00));
    send_word(make_word(FUNC_ADD, TBL_RSV, 64'h8000_0000_0000_0000, 64'h10, 4'd8, 8'hff));
    send_word(make_word(FUNC_ADD, TBL_RSV, 64'h8000_0000_0000_0010, 64'h10, 4'd8, 8'hff));
    send_word(make_word(FUNC_ADD, TBL_RSV, 64'h7fff_ffff_ffff_fff0, 64'h40, 4'd7, 8'h7f));
    send_word(make_word(FUNC_REMOVE, TBL_RSV, 64'h8000_0000_0000_0008, 64'h8, 4'd0, 8'h00));
    drain();

    // fill the reserved table past its capacity, then send removes that the full table refuses
    send_word(make_word(FUNC_REMOVE, TBL_RSV, 64'h0, ADDR_MAX, 4'd0, 8'h00));
    for (int i = 0; i < 132; i++) begin
      send_word(make_word(FUNC_ADD, TBL_RSV, 64'h1000_0000 + 64'(i * 32), 64'd16,
                          4'(i % 9), 8'(i)));
    end
    send_word(make_word(FUNC_REMOVE, TBL_RSV, 64'h1000_0000, 64'd8, 4'd0, 8'h00));
    send_word(make_word(FUNC_REMOVE, TBL_RSV, 64'h1000_0000, 64'h1000, 4'd0, 8'h00));
    drain();
    send_word(make_word(FUNC_REMOVE, TBL_RSV, 64'h0, ADDR_MAX, 4'd0, 8'h00));

    // random words, with a full drain halfway
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) drain();
      send_word(random_word());
    end
    req_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[address_range_table_add_remove_unit] OK");
    end else begin
      $display("[address_range_table_add_remove_unit] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/aru_pkg.sv
rtl/core/aru_intf.sv
rtl/core/address_range_table_add_remove_unit.sv
tb/sv/aru_scoreboard.sv
tb/sv/tb_address_range_table_add_remove_unit.sv
